>>> hw/rtl/isgf_pkg.sv
// ----------------------------------------------------------------------------
// isgf_pkg
// Shared types and constants of the greedy spin-flip search block.
// ----------------------------------------------------------------------------
package isgf_pkg;

  localparam logic [1:0] KIND_COUPLING = 2'd0;
  localparam logic [1:0] KIND_SPIN     = 2'd1;
  localparam logic [1:0] KIND_START    = 2'd2;

  localparam logic [1:0] CFG_PASS_LIMIT = 2'd0;
  localparam logic [1:0] CFG_GAIN_TOL   = 2'd1;
  localparam logic [1:0] CFG_SPINS      = 2'd2;

  localparam logic [9:0]  PASS_LIMIT_RST = 10'd100;
  localparam logic [6:0]  SPINS_RST      = 7'd64;
  localparam logic [19:0] FLIP_SAT       = 20'hFFFFF;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_W      = 24;
  localparam int OBJ_W      = 27;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIELD, ST_F_DRAIN, ST_PASS, ST_SCAN, ST_S_DRAIN, ST_DECIDE,
    ST_UPDATE, ST_U_DRAIN, ST_OBJ, ST_O_DRAIN, ST_EMIT
  } isgf_state_e;

  typedef enum logic [2:0] {
    OP_NONE, OP_FIELD, OP_SCAN, OP_UPDATE, OP_OBJ
  } isgf_op_e;

  typedef struct packed {
    isgf_op_e op;
    logic     search_start;
    logic     pass_begin;
    logic     acc_clr;
    logic     flip;
    logic     emit;
  } isgf_cmd_t;

  typedef struct packed {
    logic sweep_end;
    logic pass_go;
    logic best_gt;
    logic iter_done;
    logic emit_done;
  } isgf_status_t;

endpackage

>>> hw/rtl/isgf_ram.sv
// ----------------------------------------------------------------------------
// isgf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module isgf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/isgf_ctrl.sv
// ----------------------------------------------------------------------------
// isgf_ctrl
// Sequencer of the search: field set-up, passes of flips, objective, results.
// ----------------------------------------------------------------------------
module isgf_ctrl import isgf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_fire_i,
  input  logic [1:0]   kind_i,
  output logic         in_ready_o,
  output isgf_cmd_t    cmd_o,
  input  isgf_status_t status_i
);

  isgf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire_i && kind_i == KIND_START) state_d = ST_FIELD;
      end
      ST_FIELD:   if (status_i.sweep_end) state_d = ST_F_DRAIN;
      ST_F_DRAIN: state_d = ST_PASS;
      ST_PASS:    state_d = status_i.pass_go ? ST_SCAN : ST_OBJ;
      ST_SCAN:    if (status_i.sweep_end) state_d = ST_S_DRAIN;
      ST_S_DRAIN: state_d = ST_DECIDE;
      ST_DECIDE:  state_d = status_i.best_gt ? ST_UPDATE : ST_PASS;
      ST_UPDATE:  if (status_i.sweep_end) state_d = ST_U_DRAIN;
      ST_U_DRAIN: state_d = status_i.iter_done ? ST_PASS : ST_SCAN;
      ST_OBJ:     if (status_i.sweep_end) state_d = ST_O_DRAIN;
      ST_O_DRAIN: state_d = ST_EMIT;
      ST_EMIT:    if (status_i.emit_done) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o         = 1'b1;
        cmd_o.search_start = in_fire_i && kind_i == KIND_START;
      end
      ST_FIELD:  cmd_o.op = OP_FIELD;
      ST_PASS: begin
        cmd_o.pass_begin = status_i.pass_go;
        cmd_o.acc_clr    = !status_i.pass_go;
      end
      ST_SCAN:   cmd_o.op = OP_SCAN;
      ST_DECIDE: cmd_o.flip = status_i.best_gt;
      ST_UPDATE: cmd_o.op = OP_UPDATE;
      ST_OBJ:    cmd_o.op = OP_OBJ;
      ST_EMIT:   cmd_o.emit = 1'b1;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

>>> hw/rtl/isgf_dp.sv
// ----------------------------------------------------------------------------
// isgf_dp
// Datapath: coupling and field memories, spins, sweep counters, accumulator,
// best-gain search, pass bookkeeping and the result register.
// ----------------------------------------------------------------------------
module isgf_dp import isgf_pkg::*; #(
  parameter int MAX_SPINS      = 64,
  parameter int COUPLING_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_fire_i,
  input  logic [1:0]            kind_i,
  input  logic [5:0]            row_i,
  input  logic [5:0]            col_i,
  input  logic signed [15:0]    coup_i,
  input  logic                  spin_i,
  input  isgf_cmd_t             cmd_i,
  output isgf_status_t          status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o
);

  localparam int AW   = $clog2(MAX_SPINS);
  localparam int NW   = AW + 1;
  localparam int CW   = COUPLING_WIDTH;
  localparam int FW   = CW + AW + 1;
  localparam int GW   = FW + 1;
  localparam int CMPW = ((GW > CFG_W) ? GW : CFG_W) + 1;
  localparam int ACCW = CW + 2 * AW + 1;
  localparam int OBJX = (ACCW > OBJ_W) ? ACCW : OBJ_W;
  localparam int CAPW = NW + 3;

  // configuration
  logic [9:0]              pass_limit_q;
  logic signed [CFG_W-1:0] tol_q;
  logic [6:0]              spins_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_limit_q <= PASS_LIMIT_RST;
      tol_q        <= '0;
      spins_q      <= SPINS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PASS_LIMIT: pass_limit_q <= cfg_data_i[9:0];
        CFG_GAIN_TOL:   tol_q        <= cfg_data_i;
        CFG_SPINS:      spins_q      <= cfg_data_i[6:0];
        default:        ;
      endcase
    end
  end

  logic [NW-1:0] n_q, n_d;
  logic [AW-1:0] nm1;

  always_comb begin
    if (spins_q == 7'd0) begin
      n_d = NW'(1);
    end else if (9'(spins_q) > 9'(MAX_SPINS)) begin
      n_d = NW'(MAX_SPINS);
    end else begin
      n_d = NW'(spins_q);
    end
  end
  assign nm1 = AW'(n_q - NW'(1));

  // sweep counters
  logic [AW-1:0] ci_q, cj_q;
  logic          issue, is2d, row_end, col_end, emit_fire;
  logic          out_vld_q;

  assign issue     = cmd_i.op != OP_NONE;
  assign is2d      = cmd_i.op == OP_FIELD || cmd_i.op == OP_OBJ;
  assign row_end   = ci_q == nm1;
  assign col_end   = cj_q == nm1;
  assign emit_fire = cmd_i.emit && (!out_vld_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ci_q <= '0;
      cj_q <= '0;
    end else if (issue && is2d) begin
      if (col_end) begin
        cj_q <= '0;
        ci_q <= row_end ? '0 : ci_q + AW'(1);
      end else begin
        cj_q <= cj_q + AW'(1);
      end
    end else if (issue || emit_fire) begin
      ci_q <= row_end ? '0 : ci_q + AW'(1);
    end
  end

  // spins
  logic [MAX_SPINS-1:0] spin_q;
  logic [AW-1:0]        bidx_q;
  logic                 row_ok, col_ok;

  assign row_ok = 9'(row_i) < 9'(MAX_SPINS);
  assign col_ok = 9'(col_i) < 9'(MAX_SPINS);

  always_ff @(posedge clk_i) begin
    if (in_fire_i && kind_i == KIND_SPIN && row_ok) begin
      spin_q[AW'(row_i)] <= spin_i;
    end else if (cmd_i.flip) begin
      spin_q[bidx_q] <= ~spin_q[bidx_q];
    end
  end

  // memories
  logic [CW-1:0] coup_rdata;
  logic [FW-1:0] field_rdata, field_wdata;
  logic          field_we;
  logic          p_vld_q, p_sgn_q, p_first_q, p_last_q, p_add_q;
  isgf_op_e      p_op_q;
  logic [AW-1:0] p_i_q;

  isgf_ram #(.WIDTH(CW), .DEPTH(MAX_SPINS * MAX_SPINS)) u_coupling (
    .clk_i   (clk_i),
    .we_i    (in_fire_i && kind_i == KIND_COUPLING && row_ok && col_ok),
    .waddr_i ({AW'(row_i), AW'(col_i)}),
    .wdata_i (CW'(coup_i)),
    .raddr_i ({ci_q, (cmd_i.op == OP_UPDATE) ? bidx_q : cj_q}),
    .rdata_o (coup_rdata)
  );

  isgf_ram #(.WIDTH(FW), .DEPTH(MAX_SPINS)) u_field (
    .clk_i   (clk_i),
    .we_i    (field_we),
    .waddr_i (p_i_q),
    .wdata_i (field_wdata),
    .raddr_i (ci_q),
    .rdata_o (field_rdata)
  );

  // read stage tags travel alongside the registered memory reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      p_op_q  <= OP_NONE;
    end else begin
      p_vld_q <= issue;
      p_op_q  <= cmd_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    p_i_q     <= ci_q;
    p_last_q  <= col_end;
    p_first_q <= (cmd_i.op == OP_SCAN) ? (ci_q == '0) : (cj_q == '0);
    p_add_q   <= (cmd_i.op == OP_FIELD) || (cj_q > ci_q);
    unique case (cmd_i.op)
      OP_FIELD: p_sgn_q <= spin_q[cj_q];
      OP_OBJ:   p_sgn_q <= spin_q[ci_q] ^ spin_q[cj_q];
      default:  p_sgn_q <= spin_q[ci_q];
    endcase
  end

  // accumulator, field update, best gain
  logic signed [CW-1:0]   j_s;
  logic signed [FW-1:0]   g_s;
  logic signed [ACCW-1:0] jx, acc_q, acc_base, acc_sum;
  logic signed [GW:0]     upd;
  logic signed [GW-1:0]   gain, best_q;
  logic                   xo_q;

  assign j_s      = signed'(coup_rdata);
  assign g_s      = signed'(field_rdata);
  assign jx       = ACCW'(j_s);
  assign acc_base = (p_op_q == OP_FIELD && p_first_q) ? '0 : acc_q;
  assign acc_sum  = acc_base + (p_sgn_q ? -jx : jx);
  // a spin that was -1 raises every field by twice its coupling
  assign upd      = xo_q ? ((GW+1)'(g_s) + ((GW+1)'(j_s) <<< 1))
                         : ((GW+1)'(g_s) - ((GW+1)'(j_s) <<< 1));
  assign gain     = p_sgn_q ? ((GW)'(g_s) <<< 1) : -((GW)'(g_s) <<< 1);

  assign field_we    = p_vld_q && ((p_op_q == OP_FIELD && p_last_q) || p_op_q == OP_UPDATE);
  assign field_wdata = (p_op_q == OP_UPDATE) ? FW'(upd) : FW'(acc_sum);

  always_ff @(posedge clk_i) begin
    if (p_vld_q && (p_op_q == OP_FIELD || (p_op_q == OP_OBJ && p_add_q))) begin
      acc_q <= acc_sum;
    end else if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end
    if (p_vld_q && p_op_q == OP_SCAN && (p_first_q || gain > best_q)) begin
      best_q <= gain;
      bidx_q <= p_i_q;
    end
    if (cmd_i.flip) begin
      xo_q <= spin_q[bidx_q];
    end
  end

  // pass bookkeeping
  logic [9:0]      pass_q;
  logic [19:0]     flip_q;
  logic            improved_q;
  logic [CAPW-1:0] it_q, cap;

  assign cap = CAPW'(n_q) * CAPW'(5);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q     <= '0;
      flip_q     <= '0;
      improved_q <= 1'b0;
      it_q       <= '0;
      n_q        <= NW'(MAX_SPINS);
    end else if (cmd_i.search_start) begin
      n_q        <= n_d;
      pass_q     <= '0;
      flip_q     <= '0;
      improved_q <= 1'b1;
    end else if (cmd_i.pass_begin) begin
      pass_q     <= pass_q + 10'd1;
      improved_q <= 1'b0;
      it_q       <= '0;
    end else if (cmd_i.flip) begin
      improved_q <= 1'b1;
      it_q       <= it_q + CAPW'(1);
      if (flip_q != FLIP_SAT) flip_q <= flip_q + 20'd1;
    end
  end

  assign status_o.sweep_end = issue && row_end && (!is2d || col_end);
  assign status_o.pass_go   = improved_q && (pass_q < pass_limit_q);
  assign status_o.best_gt   = CMPW'(best_q) > CMPW'(tol_q);
  assign status_o.iter_done = it_q == cap;
  assign status_o.emit_done = emit_fire && row_end;

  // result register
  logic signed [OBJX-1:0] objx;
  logic [OUT_DATA_W-1:0]  out_data_q;
  logic                   out_last_q;

  assign objx = OBJX'(acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_data_q <= {7'd0, !improved_q, pass_q, flip_q, objx[OBJ_W-1:0],
                     spin_q[ci_q], 6'(ci_q)};
      out_last_q <= row_end;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTH
  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pass_begin |-> pass_q < pass_limit_q)
    else $error("pass started beyond the limit");
  a_flip_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flip |=> improved_q)
    else $error("flip did not mark the pass as improving");
  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> ci_q <= nm1)
    else $error("result index beyond active spins");
`endif

endmodule

>>> hw/rtl/ising_greedy_spin_flip_search.sv
// Load items are accepted only while idle. A start item builds the fields,
// opens each pass, makes flips, ends a pass with a scan that finds no flip and
// computes the objective (one memory read per cycle), then gives one result
// per cycle while the sink takes them. Reset clears control state and restores
// register defaults; the coupling, spin and field stores hold nothing defined
// until written.
// ----------------------------------------------------------------------------
// ising_greedy_spin_flip_search
// Greedy best-improvement spin-flip search over a stored Ising coupling matrix.
// ----------------------------------------------------------------------------
module ising_greedy_spin_flip_search import isgf_pkg::*; #(
  parameter int MAX_SPINS      = 64,
  parameter int COUPLING_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // row_index[5:0], col_index[11:6], coupling_value[27:12], spin_value[28]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // spin_index[5:0], spin_sign[6], objective[33:7], flip_count[53:34],
  // pass_count[63:54], converged[64]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  isgf_cmd_t    cmd;
  isgf_status_t status;
  logic         in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  isgf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .kind_i     (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  isgf_dp #(
    .MAX_SPINS      (MAX_SPINS),
    .COUPLING_WIDTH (COUPLING_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_fire_i   (in_fire),
    .kind_i      (s_axis_tuser),
    .row_i       (s_axis_tdata[5:0]),
    .col_i       (s_axis_tdata[11:6]),
    .coup_i      (signed'(s_axis_tdata[27:12])),
    .spin_i      (s_axis_tdata[28]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> tb/sv/ising_greedy_spin_flip_search_tb.sv
// ----------------------------------------------------------------------------
// ising_greedy_spin_flip_search_tb
// Loads a corner of the coupling matrix and spin vector, then runs directed and
// random searches under several register settings and stall patterns, and
// checks every result item against a local prediction of the greedy search.
// ----------------------------------------------------------------------------
module ising_greedy_spin_flip_search_tb;
  import isgf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSP = 64;
  localparam int NPRE = 8;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam longint TIMEOUT_CYCLES = 20_000_000;

  typedef struct packed {
    logic        conv;
    logic [9:0]  passes;
    logic [19:0] flips;
    logic [26:0] obj;
    logic        sign;
    logic [5:0]  idx;
    logic        last;
  } spin_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  ising_greedy_spin_flip_search dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Local copy of the block's state and registers.
  longint coupling[NSP][NSP];
  bit spin_neg[NSP];
  longint field[NSP];
  int unsigned pass_budget = PASS_LIMIT_RST;
  longint tolerance = 0;
  int unsigned active_spins = SPINS_RST;

  spin_result_t expected_spins[$];
  int mismatches = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  longint cycles = 0;

  function automatic longint spin_of(int i);
    return spin_neg[i] ? -1 : 1;
  endfunction

  function automatic void predict_search();
    int n, best, cap;
    longint best_gain, g, xo, obj;
    int unsigned passes, flips;
    bit improved;
    spin_result_t r;
    n = active_spins;
    if (n < 1) n = 1;
    if (n > NSP) n = NSP;
    for (int i = 0; i < n; i++) begin
      field[i] = 0;
      for (int j = 0; j < n; j++) field[i] += coupling[i][j] * spin_of(j);
    end
    passes = 0;
    flips = 0;
    improved = 1'b1;
    cap = 5 * n;
    while (improved && passes < pass_budget) begin
      passes++;
      improved = 1'b0;
      for (int it = 0; it < cap; it++) begin
        best = 0;
        best_gain = -2 * spin_of(0) * field[0];
        for (int i = 1; i < n; i++) begin
          g = -2 * spin_of(i) * field[i];
          if (g > best_gain) begin
            best_gain = g;
            best = i;
          end
        end
        if (best_gain <= tolerance) break;
        improved = 1'b1;
        if (flips < FLIP_SAT) flips++;
        xo = spin_of(best);
        spin_neg[best] = ~spin_neg[best];
        for (int i = 0; i < n; i++) field[i] -= 2 * xo * coupling[i][best];
      end
    end
    obj = 0;
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++) obj += coupling[i][j] * spin_of(i) * spin_of(j);
    for (int i = 0; i < n; i++) begin
      r.idx = i[5:0];
      r.sign = spin_neg[i];
      r.obj = obj[26:0];
      r.flips = flips[19:0];
      r.passes = passes[9:0];
      r.conv = ~improved;
      r.last = (i == n - 1);
      expected_spins.push_back(r);
    end
  endfunction

  task automatic send_item(logic [1:0] kind, int row, int col, int cval, bit sv);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {3'b000, sv, cval[15:0], col[5:0], row[5:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    case (kind)
      KIND_COUPLING: coupling[row][col] = longint'(signed'(cval[15:0]));
      KIND_SPIN:     spin_neg[row] = sv;
      KIND_START:    predict_search();
      default: ;
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_spins.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    s_axis_tvalid <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PASS_LIMIT: pass_budget = value & 32'h3FF;
      CFG_GAIN_TOL:   tolerance = longint'(signed'(value[23:0]));
      CFG_SPINS:      active_spins = value & 32'h7F;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic int random_coupling();
    case ($urandom_range(7))
      0: return -32768;
      1: return 32767;
      default: return $urandom_range(8191) - 4096;
    endcase
  endfunction

  // The leading corner of the matrix and its spins are preloaded first, and every
  // search stays inside it, so that no search ever reads an unset entry.
  task automatic test_preload();
    for (int r = 0; r < NPRE; r++)
      for (int c = 0; c < NPRE; c++) send_item(KIND_COUPLING, r, c, random_coupling(), 1'b0);
    for (int r = 0; r < NPRE; r++) send_item(KIND_SPIN, r, 0, 0, $urandom_range(1));
  endtask

  task automatic test_default_search();
    write_reg(CFG_SPINS, NPRE);
    send_item(KIND_START, 0, 0, 0, 1'b0);
    drain();
  endtask

  // One spin with the lowest tolerance never converges and runs every pass.
  task automatic test_single_spin_endless();
    write_reg(CFG_SPINS, 0);
    write_reg(CFG_GAIN_TOL, -8388608);
    write_reg(CFG_PASS_LIMIT, 1023);
    send_item(KIND_START, 0, 0, 0, 1'b0);
    drain();
  endtask

  task automatic test_zero_passes();
    write_reg(CFG_SPINS, NPRE);
    write_reg(CFG_PASS_LIMIT, 0);
    write_reg(CFG_GAIN_TOL, 0);
    send_item(KIND_START, 0, 0, 0, 1'b0);
    drain();
  endtask

  task automatic test_corners_high_tolerance();
    write_reg(CFG_SPINS, NPRE);
    write_reg(CFG_PASS_LIMIT, 1);
    write_reg(CFG_GAIN_TOL, 8388607);
    send_item(KIND_COUPLING, NPRE - 1, NPRE - 1, -32768, 1'b1);
    send_item(KIND_COUPLING, 0, NPRE - 1, 32767, 1'b0);
    send_item(KIND_COUPLING, NPRE - 1, 0, -1, 1'b0);
    send_item(KIND_SPIN, NPRE - 1, 63, 32767, 1'b1);
    send_item(KIND_SPIN, 0, 0, 0, 1'b0);
    send_item(KIND_UNKNOWN, 63, 63, -1, 1'b1);
    send_item(KIND_START, 63, 63, -1, 1'b1);
    drain();
  endtask

  task automatic test_random(int tx_pct, int rx_pct, int count);
    int n, k;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    n = $urandom_range(2, NPRE);
    write_reg(CFG_SPINS, n);
    write_reg(CFG_PASS_LIMIT, $urandom_range(1, 30));
    write_reg(CFG_GAIN_TOL, int'($urandom_range(12288)) - 4096);
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(15);
      if (k < 9)
        send_item(KIND_COUPLING, $urandom_range(n - 1), $urandom_range(n - 1),
                  random_coupling(), $urandom_range(1));
      else if (k < 12)
        send_item(KIND_SPIN, $urandom_range(n - 1), $urandom_range(63),
                  $urandom_range(65535), $urandom_range(1));
      else if (k < 13)
        send_item($urandom_range(1) ? KIND_UNKNOWN : KIND_COUPLING, $urandom_range(63),
                  $urandom_range(63), random_coupling(), $urandom_range(1));
      else
        send_item(KIND_START, $urandom_range(63), $urandom_range(63),
                  $urandom_range(65535), $urandom_range(1));
    end
    drain();
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    spin_result_t got, want;
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[64:0], m_axis_tlast};
      if (expected_spins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
      end else begin
        want = expected_spins.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: idx %0d/%0d sign %0d/%0d obj %h/%h flips %0d/%0d %s",
                     want.idx, got.idx, want.sign, got.sign, want.obj, got.obj,
                     want.flips, got.flips,
                     $sformatf("passes %0d/%0d conv %0d/%0d last %0d/%0d",
                               want.passes, got.passes, want.conv, got.conv,
                               want.last, got.last));
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_preload();
    test_default_search();
    test_single_spin_endless();
    test_zero_passes();
    test_corners_high_tolerance();
    for (int p = 0; p < 2; p++) test_random(13, 57, 16);
    for (int p = 0; p < 2; p++) test_random(57, 13, 16);
    for (int p = 0; p < 2; p++) test_random(0, 0, 16);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_spins.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/isgf_pkg.sv
hw/rtl/isgf_ram.sv
hw/rtl/isgf_ctrl.sv
hw/rtl/isgf_dp.sv
hw/rtl/ising_greedy_spin_flip_search.sv
tb/sv/ising_greedy_spin_flip_search_tb.sv
